// File: rtl/serial_rx_ring_buffer_with_echo_core_defines.svh
// ----------------------------------------------------------------------------
// serial rx ring buffer with echo - assertion macros
// Shared concurrent check macros, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_RX_RING_BUFFER_WITH_ECHO_CORE_DEFINES_SVH
`define SERIAL_RX_RING_BUFFER_WITH_ECHO_CORE_DEFINES_SVH

// same-cycle implication
`define SRRB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srrb check failed");

// next-cycle implication
`define SRRB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srrb check failed");

`endif

// File: rtl/srrb_pkg.sv
// ----------------------------------------------------------------------------
// srrb_pkg
// Types, codes and sizing constants of the serial rx ring buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srrb_pkg;

  localparam int RING_DEPTH = 128;
  localparam int MAX_BURST  = 64;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int LEN_W      = 7;
  localparam int CNT_W      = $clog2(MAX_BURST + 1);
  localparam int MAX_PC_W   = (PTR_W > CNT_W) ? PTR_W : CNT_W;
  localparam int CMP_W      = ((MAX_PC_W > LEN_W) ? MAX_PC_W : LEN_W) + 1;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_BURST = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic             command;
    logic [7:0]       rx_byte;
    logic [LEN_W-1:0] read_len;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: rtl/srrb_ram.sv
// ----------------------------------------------------------------------------
// srrb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srrb_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/srrb_out_reg.sv
// ----------------------------------------------------------------------------
// srrb_out_reg
// Output register holding one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srrb_out_reg
  import srrb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t item_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      valid_q, valid_d;
  out_item_t item_q, item_d;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load_i) begin
      valid_d = 1'b1;
      item_d  = item_i;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = item_q;

endmodule

// File: rtl/srrb_ctrl.sv
// ----------------------------------------------------------------------------
// srrb_ctrl
// Pointer state and sequencer: stores and echoes bytes, runs read bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srrb_ctrl
  import srrb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output ram_req_t         ram_req_o,
  input  logic [7:0]       ram_rdata_i,
  input  logic             out_free_i,
  output logic             out_load_o,
  output out_item_t        out_item_o
);

  ctrl_state_e      state_q, state_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] remain_q, remain_d;

  logic [PTR_W-1:0] head_nxt;
  logic [PTR_W-1:0] tail_nxt;
  logic [CMP_W-1:0] avail;
  logic [CMP_W-1:0] want;
  logic [CMP_W-1:0] count;

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_nxt = next_pos(head_q);
  assign tail_nxt = next_pos(tail_q);

  always_comb begin
    if (tail_q >= head_q) begin
      avail = CMP_W'(tail_q) - CMP_W'(head_q);
    end else begin
      avail = CMP_W'(tail_q) + CMP_W'(RING_DEPTH) - CMP_W'(head_q);
    end
    if (CMP_W'(in_data_i.read_len) > CMP_W'(MAX_BURST)) begin
      want = CMP_W'(MAX_BURST);
    end else begin
      want = CMP_W'(in_data_i.read_len);
    end
    count = (want < avail) ? want : avail;
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    remain_d   = remain_q;
    in_stall_o = !((state_q == ST_IDLE) && out_free_i);
    ram_req_o  = '{we: 1'b0, waddr: tail_q, wdata: in_data_i.rx_byte,
                   re: 1'b0, raddr: head_q};
    out_load_o = 1'b0;
    out_item_o = '{kind: KIND_ECHO, data: '0, last: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && out_free_i) begin
          if (in_data_i.command == CMD_STORE) begin
            if (tail_nxt != head_q) begin
              ram_req_o.we = 1'b1;
              tail_d       = tail_nxt;
              out_load_o   = 1'b1;
              out_item_o   = '{kind: KIND_ECHO, data: in_data_i.rx_byte, last: 1'b1};
            end
          end else if (in_data_i.read_len != '0) begin
            if (head_q == tail_q) begin
              out_load_o = 1'b1;
              out_item_o = '{kind: KIND_EMPTY, data: '0, last: 1'b1};
            end else begin
              ram_req_o.re = 1'b1;
              remain_d     = CNT_W'(count);
              state_d      = ST_BURST;
            end
          end
        end
      end
      ST_BURST: begin
        // data of the last issued read is held on ram_rdata_i
        if (out_free_i) begin
          out_load_o = 1'b1;
          out_item_o = '{kind: KIND_READ, data: ram_rdata_i,
                         last: (remain_q == CNT_W'(1))};
          head_d     = head_nxt;
          remain_d   = remain_q - 1'b1;
          if (remain_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = head_nxt;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      remain_q <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      remain_q <= remain_d;
    end
  end

endmodule

// File: rtl/serial_rx_ring_buffer_with_echo_core.sv
// A stored byte is echoed in the cycle after its transaction is taken; a full
// buffer drops the byte without a result. A read of n bytes (n = the smaller
// of read_len, saturated at 64, and the bytes held) first waits for the
// memory read, then moves one byte per cycle while the output register is
// free, through the single read port and the output register. Input stays
// stalled for the whole burst and whenever the output register is full and
// stalled. Stores, empty reads and zero-length reads keep the block idle.
// Up to 127 bytes are held; the storage needs no clearing after reset.
// ----------------------------------------------------------------------------
// serial_rx_ring_buffer_with_echo_core
// Receive ring buffer for serial bytes with echo and burst reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_rx_ring_buffer_with_echo_core_defines.svh"

module serial_rx_ring_buffer_with_echo_core
  import srrb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  ram_req_t   ram_req;
  logic [7:0] ram_rdata;
  logic       out_free;
  logic       out_load;
  out_item_t  out_item;

  srrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .out_item_o  (out_item)
  );

  srrb_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (8),
    .AW    (PTR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  srrb_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .item_i      (out_item),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `SRRB_ASSERT_IMP(a_no_overwrite, out_load, out_free)
  `SRRB_ASSERT_IMP(a_no_rw_overlap, ram_req.we, !ram_req.re)
  `SRRB_ASSERT_NXT(a_load_shows, out_load, out_valid_o && (out_data_o == $past(out_item)))
  `SRRB_ASSERT_IMP(a_empty_final, out_valid_o && (out_data_o.kind == KIND_EMPTY), out_data_o.last && (out_data_o.data == 8'h00))

endmodule

// File: tb/srrb_ring_checker.sv
// ----------------------------------------------------------------------------
// srrb_ring_checker
// Watches both channels of the serial rx ring buffer. It keeps a shadow copy
// of the ring, works out the echo, read and empty results of every accepted
// input transaction, and compares each accepted output transaction with the
// oldest one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srrb_ring_checker
  import srrb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        mismatch_cnt_o,
  output int        outstanding_o
);

  logic [7:0]  ring_copy [RING_DEPTH];
  int unsigned rd_pos;
  int unsigned wr_pos;
  out_item_t   due_results_q[$];
  int          mismatches = 0;

  assign mismatch_cnt_o = mismatches;

  task automatic report(input string what, input int got_v, input int want_v);
    $display("%0t ns srrb mismatch: %s got %0d want %0d", $realtime, what, got_v, want_v);
    mismatches++;
  endtask

  task automatic predict_ring(input in_item_t it);
    int unsigned held;
    int unsigned burst;
    int unsigned k;
    if (it.command == CMD_STORE) begin
      // full ring drops the byte silently
      if ((wr_pos + 1) % RING_DEPTH == rd_pos) return;
      ring_copy[wr_pos] = it.rx_byte;
      wr_pos = (wr_pos + 1) % RING_DEPTH;
      due_results_q.push_back('{kind: KIND_ECHO, data: it.rx_byte, last: 1'b1});
      return;
    end
    if (it.read_len == '0) return;
    burst = (it.read_len > MAX_BURST) ? MAX_BURST : it.read_len;
    held = (wr_pos + RING_DEPTH - rd_pos) % RING_DEPTH;
    if (held == 0) begin
      due_results_q.push_back('{kind: KIND_EMPTY, data: 8'h00, last: 1'b1});
      return;
    end
    if (held < burst) burst = held;
    for (k = 0; k < burst; k++) begin
      due_results_q.push_back('{kind: KIND_READ, data: ring_copy[rd_pos],
                                last: (k + 1 == burst)});
      rd_pos = (rd_pos + 1) % RING_DEPTH;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t got;
    out_item_t want;
    if (!rst_ni) begin
      rd_pos = 0;
      wr_pos = 0;
      due_results_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (due_results_q.size() == 0) begin
          report("unexpected result", got, 0);
        end else begin
          want = due_results_q.pop_front();
          if (got.kind !== want.kind) report("kind", got.kind, want.kind);
          if (got.data !== want.data) report("data", got.data, want.data);
          if (got.last !== want.last) report("last", got.last, want.last);
        end
      end
      if (in_valid_i && !in_stall_i) predict_ring(in_data_i);
      outstanding_o <= due_results_q.size();
    end
  end

endmodule

// File: tb/tb_serial_rx_ring_buffer_with_echo_core.sv
// ----------------------------------------------------------------------------
// tb_serial_rx_ring_buffer_with_echo_core
// Drives stores and burst reads into the ring buffer: a directed opening on
// the edge cases, then a fill past full, a drain past empty and a random mix,
// with bursty input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_serial_rx_ring_buffer_with_echo_core;
  import srrb_pkg::*;

  localparam int LIMIT_CYCLES     = 300000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 20;
  localparam int FILL_ITEMS       = 160;
  localparam int DRAIN_ITEMS      = 40;
  localparam int MIX_ITEMS        = 110;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_e;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int   mismatch_cnt;
  int   outstanding;
  int   cycle_cnt = 0;
  int   burst_left = 0;
  logic long_hold_req;
  logic hold_done = 1'b0;

  always #2 clk = ~clk;

  serial_rx_ring_buffer_with_echo_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  srrb_ring_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding)
  );

  function automatic in_item_t store_item(input logic [7:0] b);
    in_item_t it;
    it.command  = CMD_STORE;
    it.rx_byte  = b;
    it.read_len = LEN_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(input logic [LEN_W-1:0] len);
    in_item_t it;
    it.command  = CMD_READ;
    it.rx_byte  = 8'($urandom);
    it.read_len = len;
    return it;
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LEN_W'($urandom_range(MAX_BURST + 1, 127));
      2: return LEN_W'(MAX_BURST);
      3, 4: return LEN_W'($urandom_range(9, MAX_BURST));
      default: return LEN_W'($urandom_range(1, 8));
    endcase
  endfunction

  // one transaction; a gap opens whenever the current burst is used up
  task automatic push_item(input in_item_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    burst_left = 0;
  endtask

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // receiver stall pattern
  initial begin
    stall_mode_e mode;
    int          span;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = stall_mode_e'($urandom_range(STALL_NONE, STALL_HEAVY));
        span = $urandom_range(8, 48);
        repeat (span) begin
          case (mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
            default:     out_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    long_hold_req <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stores with empty ring, zero length and saturated reads
    push_item(read_item(7'd1));
    push_item(read_item(7'd0));
    push_item(read_item(7'd127));
    push_item(store_item(8'h00));
    push_item(store_item(8'hFF));
    push_item(store_item(8'hAA));
    push_item(store_item(8'h55));
    push_item(read_item(7'd0));
    push_item(read_item(7'd2));
    push_item(read_item(7'd127));
    push_item(read_item(7'd64));
    push_item(store_item(8'h80));
    push_item(store_item(8'h01));
    push_item(read_item(7'd100));
    push_item(read_item(7'd65));
    push_item(store_item(8'h7F));
    push_item(store_item(8'hFE));
    push_item(read_item(7'd64));
    push_item(read_item(7'd1));
    wait_drained();

    // fill past full, starting with the long output hold-off
    long_hold_req <= 1'b1;
    repeat (FILL_ITEMS) begin
      if ($urandom_range(0, 19) == 0) push_item(read_item(LEN_W'($urandom_range(0, 2))));
      else push_item(store_item(8'($urandom)));
    end

    // read-heavy stretch, runs the ring dry
    repeat (DRAIN_ITEMS) begin
      if ($urandom_range(0, 3) == 0) push_item(store_item(8'($urandom)));
      else push_item(read_item(rand_len()));
    end

    repeat (MIX_ITEMS) begin
      if ($urandom_range(0, 1) == 0) push_item(store_item(8'($urandom)));
      else push_item(read_item(rand_len()));
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/srrb_pkg.sv
rtl/srrb_ram.sv
rtl/srrb_out_reg.sv
rtl/srrb_ctrl.sv
rtl/serial_rx_ring_buffer_with_echo_core.sv
tb/srrb_ring_checker.sv
tb/tb_serial_rx_ring_buffer_with_echo_core.sv
